>>> rtl/qrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg
// shared widths, status codes and side-band structs of the quadratic root solver
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int CoefWidth = 16;
  localparam int CoefFrac = CoefWidth / 2;
  localparam int RootFracBits = 16;
  localparam int DiscWidth = 34;
  localparam int RootWidth = 40;

  localparam int RadWidth = 50;
  localparam int SqrtBits = RadWidth / 2;
  localparam int SqrtRemWidth = SqrtBits + 3;
  localparam int NbWidth = CoefWidth + RootFracBits - CoefFrac + 1;
  localparam int NumWidth = SqrtBits + 1;
  localparam int DivNumWidth = NumWidth + CoefFrac;
  localparam int DenWidth = CoefWidth + 1;

  localparam logic [1:0] StTwo = 2'd0;
  localparam logic [1:0] StOne = 2'd1;
  localparam logic [1:0] StNone = 2'd2;
  localparam logic [1:0] StAZero = 2'd3;

  typedef struct packed {
    logic [1:0] status;
    logic signed [DiscWidth-1:0] disc;
    logic signed [NbWidth-1:0] nb;
    logic [DenWidth-1:0] den;
    logic a_neg;
  } side1_t;

  typedef struct packed {
    logic [1:0] status;
    logic signed [DiscWidth-1:0] disc;
    logic neg1;
    logic neg2;
  } side2_t;

endpackage

>>> rtl/qrs_disc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_disc
// two-stage discriminant, case classification and square-root radicand
// ----------------------------------------------------------------------------
module qrs_disc (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_vld,
  input  logic signed [qrs_pkg::CoefWidth-1:0] coef_a,
  input  logic signed [qrs_pkg::CoefWidth-1:0] coef_b,
  input  logic signed [qrs_pkg::CoefWidth-1:0] coef_c,
  output logic out_vld,
  output qrs_pkg::side1_t side,
  output logic [qrs_pkg::RadWidth-1:0] rad
);

  localparam int PW = 2 * qrs_pkg::CoefWidth;

  logic vld1_r, vld2_r;
  logic signed [PW-1:0] bb_r, ac_r;
  logic signed [qrs_pkg::CoefWidth-1:0] a1_r, b1_r;
  qrs_pkg::side1_t side_r, side_nxt;
  logic [qrs_pkg::RadWidth-1:0] rad_r, rad_nxt;
  logic signed [qrs_pkg::DiscWidth-1:0] disc;
  logic signed [qrs_pkg::NbWidth-1:0] bmag;

  always_comb begin
    disc = {{(qrs_pkg::DiscWidth-PW){bb_r[PW-1]}}, bb_r}
         - ({{(qrs_pkg::DiscWidth-PW){ac_r[PW-1]}}, ac_r} <<< 2);
    bmag = {{(qrs_pkg::NbWidth-qrs_pkg::CoefWidth){b1_r[qrs_pkg::CoefWidth-1]}}, b1_r}
         <<< (qrs_pkg::RootFracBits - qrs_pkg::CoefFrac);
    side_nxt.disc = disc;
    side_nxt.nb = -bmag;
    side_nxt.a_neg = a1_r[qrs_pkg::CoefWidth-1];
    side_nxt.den = a1_r[qrs_pkg::CoefWidth-1]
                 ? qrs_pkg::DenWidth'(-{a1_r[qrs_pkg::CoefWidth-1], a1_r}) << 1
                 : qrs_pkg::DenWidth'({a1_r[qrs_pkg::CoefWidth-1], a1_r}) << 1;
    if (a1_r == '0) begin
      side_nxt.status = qrs_pkg::StAZero;
    end else if (disc < 0) begin
      side_nxt.status = qrs_pkg::StNone;
    end else if (disc != '0) begin
      side_nxt.status = qrs_pkg::StTwo;
    end else begin
      side_nxt.status = qrs_pkg::StOne;
    end
    if (disc < 0) begin
      rad_nxt = '0;
    end else begin
      rad_nxt = qrs_pkg::RadWidth'(disc) <<
                (2 * qrs_pkg::RootFracBits - qrs_pkg::CoefWidth);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bb_r <= coef_b * coef_b;
      ac_r <= coef_a * coef_c;
      a1_r <= coef_a;
      b1_r <= coef_b;
      side_r <= side_nxt;
      rad_r <= rad_nxt;
    end
  end

  assign out_vld = vld2_r;
  assign side = side_r;
  assign rad = rad_r;

endmodule

>>> rtl/qrs_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module qrs_sqrt (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_vld,
  input  logic [qrs_pkg::RadWidth-1:0] rad,
  output logic out_vld,
  output logic [qrs_pkg::SqrtBits-1:0] root
);

  localparam int N = qrs_pkg::SqrtBits;
  localparam int RW = qrs_pkg::SqrtRemWidth;
  localparam int XW = qrs_pkg::RadWidth;

  logic [XW-1:0] x_r [1:N];
  logic [RW-1:0] rem_r [1:N];
  logic [N-1:0] root_r [1:N];
  logic [N:1] vld_r;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [XW-1:0] x_in;
    logic [RW-1:0] rem_in, rem_sh, trial;
    logic [N-1:0] root_in;
    logic v_in, ge;
    if (k == 0) begin : g_first
      assign x_in = rad;
      assign rem_in = '0;
      assign root_in = '0;
      assign v_in = in_vld;
    end else begin : g_next
      assign x_in = x_r[k];
      assign rem_in = rem_r[k];
      assign root_in = root_r[k];
      assign v_in = vld_r[k];
    end
    assign rem_sh = {rem_in[RW-3:0], x_in[XW-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge = rem_sh >= trial;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= v_in;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k+1] <= x_in << 2;
        rem_r[k+1] <= ge ? rem_sh - trial : rem_sh;
        root_r[k+1] <= {root_in[N-2:0], ge};
      end
    end
  end

  assign out_vld = vld_r[N];
  assign root = root_r[N];

endmodule

>>> rtl/qrs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module qrs_div (
  input  logic clk,
  input  logic en,
  input  logic [qrs_pkg::DivNumWidth-1:0] num,
  input  logic [qrs_pkg::DenWidth-1:0] den,
  output logic [qrs_pkg::DivNumWidth-1:0] quot
);

  localparam int N = qrs_pkg::DivNumWidth;
  localparam int DW = qrs_pkg::DenWidth;

  logic [N-1:0] n_r [1:N];
  logic [N-1:0] q_r [1:N];
  logic [DW:0] rem_r [1:N];
  logic [DW-1:0] den_r [1:N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [N-1:0] n_in, q_in;
    logic [DW:0] rem_in, rem_sh;
    logic [DW-1:0] d_in;
    logic ge;
    if (k == 0) begin : g_first
      assign n_in = num;
      assign q_in = '0;
      assign rem_in = '0;
      assign d_in = den;
    end else begin : g_next
      assign n_in = n_r[k];
      assign q_in = q_r[k];
      assign rem_in = rem_r[k];
      assign d_in = den_r[k];
    end
    assign rem_sh = {rem_in[DW-1:0], n_in[N-1]};
    assign ge = rem_sh >= {1'b0, d_in};
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k+1] <= n_in << 1;
        q_r[k+1] <= {q_in[N-2:0], ge};
        rem_r[k+1] <= ge ? rem_sh - {1'b0, d_in} : rem_sh;
        den_r[k+1] <= d_in;
      end
    end
  end

  assign quot = q_r[N];

endmodule

>>> rtl/quadratic_root_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver
// real roots of a*x^2 + b*x + c for a stream of Q8.8 coefficient triples
// ----------------------------------------------------------------------------
// in_ beats carry coef_a, coef_b and coef_c; each gives exactly one out_ beat
// with status, the exact Q18.16 discriminant and two Q24.16 roots.
// throughput: one beat per cycle while out_ready allows, with no bubbles between items.
// stages from input acceptance to out_valid: a 2-stage
// discriminant, 25-stage square root (one root bit per stage), one sum stage,
// a 34-stage divider pair (one quotient bit per stage) and the output register.
// the whole pipeline advances together; when the receiver holds out_ready low
// with a result waiting, every stage freezes and in_ready falls, so nothing is
// lost or repeated. bubbles still drain while the output is empty.
// reset (synchronous, active low) clears every stage valid bit; data registers
// are not reset. status 3 (a zero) and 2 (no real roots) give zero roots,
// status 1 gives a zero second root.
// ----------------------------------------------------------------------------
module quadratic_root_solver (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [15:0] in_coef_a,
  input  logic signed [15:0] in_coef_b,
  input  logic signed [15:0] in_coef_c,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] out_status,
  output logic signed [33:0] out_disc_value,
  output logic signed [39:0] out_first_root,
  output logic signed [39:0] out_second_root
);

  localparam int SqN = qrs_pkg::SqrtBits;
  localparam int DvN = qrs_pkg::DivNumWidth;
  localparam int NW = qrs_pkg::NumWidth;
  localparam int RW = qrs_pkg::RootWidth;

  logic en;
  logic d_vld, s_vld;
  qrs_pkg::side1_t d_side;
  logic [qrs_pkg::RadWidth-1:0] d_rad;
  logic [SqN-1:0] s_root;

  qrs_pkg::side1_t sd_r [1:SqN];

  logic a_vld_r;
  qrs_pkg::side2_t a_side_r, a_side_nxt;
  logic [DvN-1:0] num1_nxt, num2_nxt;
  logic [qrs_pkg::DenWidth-1:0] den_r;
  logic [DvN-1:0] num1_r, num2_r;
  logic signed [NW:0] n1, n2;

  logic [DvN:1] dv_r;
  qrs_pkg::side2_t dd_r [1:DvN];
  logic [DvN-1:0] q1, q2;

  logic out_valid_r;
  logic [1:0] status_r;
  logic signed [33:0] disc_r;
  logic signed [RW-1:0] r1_r, r2_r, r1_nxt, r2_nxt;

  assign en = !out_valid_r || out_ready;
  assign in_ready = en;

  qrs_disc u_disc (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(in_valid && en),
    .coef_a(in_coef_a), .coef_b(in_coef_b), .coef_c(in_coef_c),
    .out_vld(d_vld), .side(d_side), .rad(d_rad)
  );

  qrs_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(d_vld), .rad(d_rad),
    .out_vld(s_vld), .root(s_root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[1] <= d_side;
      for (int i = 2; i <= SqN; i++) begin
        sd_r[i] <= sd_r[i-1];
      end
    end
  end

  // sum stage: -b +/- s as sign and magnitude, scaled for the divide
  always_comb begin
    n1 = {{(NW+1-qrs_pkg::NbWidth){sd_r[SqN].nb[qrs_pkg::NbWidth-1]}}, sd_r[SqN].nb}
       + $signed({2'b00, s_root});
    n2 = {{(NW+1-qrs_pkg::NbWidth){sd_r[SqN].nb[qrs_pkg::NbWidth-1]}}, sd_r[SqN].nb}
       - $signed({2'b00, s_root});
    num1_nxt = DvN'(n1[NW] ? NW'(-n1) : NW'(n1)) << qrs_pkg::CoefFrac;
    num2_nxt = DvN'(n2[NW] ? NW'(-n2) : NW'(n2)) << qrs_pkg::CoefFrac;
    a_side_nxt.status = sd_r[SqN].status;
    a_side_nxt.disc = sd_r[SqN].disc;
    a_side_nxt.neg1 = n1[NW] ^ sd_r[SqN].a_neg;
    a_side_nxt.neg2 = n2[NW] ^ sd_r[SqN].a_neg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side_r <= a_side_nxt;
      num1_r <= num1_nxt;
      num2_r <= num2_nxt;
      den_r <= sd_r[SqN].den;
    end
  end

  qrs_div u_div1 (.clk(clk), .en(en), .num(num1_r), .den(den_r), .quot(q1));
  qrs_div u_div2 (.clk(clk), .en(en), .num(num2_r), .den(den_r), .quot(q2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else if (en) begin
      dv_r <= {dv_r[DvN-1:1], a_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd_r[1] <= a_side_r;
      for (int i = 2; i <= DvN; i++) begin
        dd_r[i] <= dd_r[i-1];
      end
    end
  end

  // quotient fits the root width, so no clamp is reached
  always_comb begin
    r1_nxt = dd_r[DvN].neg1 ? -$signed(RW'(q1)) : $signed(RW'(q1));
    r2_nxt = dd_r[DvN].neg2 ? -$signed(RW'(q2)) : $signed(RW'(q2));
    if (dd_r[DvN].status == qrs_pkg::StNone || dd_r[DvN].status == qrs_pkg::StAZero) begin
      r1_nxt = '0;
    end
    if (dd_r[DvN].status != qrs_pkg::StTwo) begin
      r2_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_r[DvN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status_r <= dd_r[DvN].status;
      disc_r <= dd_r[DvN].disc;
      r1_r <= r1_nxt;
      r2_r <= r2_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = status_r;
  assign out_disc_value = disc_r;
  assign out_first_root = r1_r;
  assign out_second_root = r2_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_first_root)
                                 && $stable(out_second_root))
    else $error("result changed while stalled");

  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline frozen");

  a_no_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == qrs_pkg::StNone || out_status == qrs_pkg::StAZero)
    |-> out_first_root == '0 && out_second_root == '0)
    else $error("root given without real roots");

  a_one_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == qrs_pkg::StOne |-> out_second_root == '0 && out_disc_value == '0)
    else $error("single root case inconsistent");

endmodule

>>> bench/quadratic_root_solver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_tb
// streams coefficient triples through the root solver and checks every beat
// ----------------------------------------------------------------------------
// a queue of triples (directed corners, then random with corner-biased fields)
// feeds a clocked driver with random gaps; a clocked monitor with random
// stalls compares each result beat against roots computed in the bench.
// ----------------------------------------------------------------------------
module quadratic_root_solver_tb;

  typedef struct {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
  } triple_t;

  typedef struct {
    logic [1:0] status;
    logic [33:0] disc;
    logic [39:0] r1;
    logic [39:0] r2;
  } roots_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_coef_a = '0;
  logic signed [15:0] in_coef_b = '0;
  logic signed [15:0] in_coef_c = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic signed [33:0] out_disc_value;
  logic signed [39:0] out_first_root;
  logic signed [39:0] out_second_root;

  triple_t pending_triples[$];
  roots_t expected_roots[$];
  int errors = 0;
  bit stim_done = 1'b0;
  bit hold_for_drain = 1'b0;
  int send_gap = 0;
  int stall_gap = 0;

  quadratic_root_solver dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic logic [39:0] divide_root(longint num, longint a);
    logic [63:0] mag;
    logic [63:0] q;
    logic neg;
    mag = (num < 0) ? -num : num;
    q = (mag << qrs_pkg::CoefFrac) / (((a < 0) ? -a : a) * 2);
    neg = (num < 0) != (a < 0);
    if (neg) begin
      if (q > (64'd1 << 39)) q = 64'd1 << 39;
      return 40'(-q);
    end
    if (q > (64'd1 << 39) - 1) q = (64'd1 << 39) - 1;
    return 40'(q);
  endfunction

  function automatic roots_t solve_quadratic(triple_t t);
    roots_t res;
    longint a, b, c, disc, s, nb;
    a = t.a;
    b = t.b;
    c = t.c;
    disc = b * b - 4 * (a * c);
    res.disc = 34'(disc);
    res.r1 = '0;
    res.r2 = '0;
    if (a == 0) begin
      res.status = qrs_pkg::StAZero;
    end else if (disc < 0) begin
      res.status = qrs_pkg::StNone;
    end else begin
      s = longint'(isqrt(64'(disc) << (2 * qrs_pkg::RootFracBits - qrs_pkg::CoefWidth)));
      nb = -b * (longint'(1) << (qrs_pkg::RootFracBits - qrs_pkg::CoefFrac));
      res.status = (disc > 0) ? qrs_pkg::StTwo : qrs_pkg::StOne;
      res.r1 = divide_root(nb + s, a);
      if (disc > 0) res.r2 = divide_root(nb - s, a);
    end
    return res;
  endfunction

  function automatic logic [15:0] pick_field();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(int'($urandom_range(0, 8)) - 4);
      3: return 16'(int'($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_triple(int a, int b, int c);
    triple_t t;
    t.a = 16'(a);
    t.b = 16'(b);
    t.c = 16'(c);
    pending_triples.push_back(t);
  endtask

  initial begin
    int k, r;
    add_triple(0, 0, 0);
    add_triple(0, 300, 7);
    add_triple(256, 0, -256);
    add_triple(256, -512, 256);
    add_triple(256, 0, 256);
    add_triple(-32768, -32768, -32768);
    add_triple(32767, 32767, 32767);
    add_triple(-32768, 32767, 32767);
    add_triple(32767, -32768, -32768);
    add_triple(1, 32767, 0);
    add_triple(1, -32768, 0);
    add_triple(-1, 32767, 0);
    add_triple(1, 0, -32768);
    add_triple(-1, 0, 32767);
    add_triple(512, 1024, 512);
    add_triple(-256, 0, 0);
    add_triple(-1, -1, -1);
    add_triple(16'hffff, 0, 16'h5555);
    add_triple(16'haaaa, 16'h5555, 0);
    for (k = 0; k < 1330; k++) begin
      r = int'($urandom_range(0, 9));
      if (r == 0) begin
        // perfect square: b = 2*sqrt(a*c)-style repeated root
        add_triple(int'($urandom_range(1, 64)) * 16, 0, 0);
      end else begin
        add_triple(int'($signed(pick_field())), int'($signed(pick_field())),
                   int'($signed(pick_field())));
      end
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    triple_t t;
    int gap;
    logic nxt_valid;
    if (rst_n) begin
      gap = send_gap;
      nxt_valid = in_valid;
      if (in_valid && in_ready) begin
        expected_roots.push_back(solve_quadratic(pending_triples.pop_front()));
        nxt_valid = 1'b0;
        gap = $urandom_range(0, 10);
        if (pending_triples.size() == 700) hold_for_drain = 1'b1;
      end
      if (!(in_valid && !in_ready)) begin
        if (hold_for_drain && expected_roots.size() == 0) begin
          hold_for_drain = 1'b0;
        end
        if (gap > 0) begin
          gap--;
        end else if (!hold_for_drain && pending_triples.size() > 0) begin
          t = pending_triples[0];
          in_coef_a <= t.a;
          in_coef_b <= t.b;
          in_coef_c <= t.c;
          nxt_valid = 1'b1;
        end else if (pending_triples.size() == 0) begin
          stim_done <= 1'b1;
        end
      end
      in_valid <= nxt_valid;
      send_gap <= gap;
    end
  end

  always @(posedge clk) begin
    roots_t e;
    int gap;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_roots.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          e = expected_roots.pop_front();
          if (out_status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_status);
            errors++;
          end
          if (out_disc_value !== e.disc) begin
            $error("disc_value expected %0h actual %0h", e.disc, out_disc_value);
            errors++;
          end
          if (out_first_root !== e.r1) begin
            $error("first_root expected %0h actual %0h", e.r1, out_first_root);
            errors++;
          end
          if (out_second_root !== e.r2) begin
            $error("second_root expected %0h actual %0h", e.r2, out_second_root);
            errors++;
          end
        end
      end
      if (stall_gap > 0) begin
        out_ready <= 1'b0;
        stall_gap <= stall_gap - 1;
      end else if (out_ready && out_valid) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if (gap == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          stall_gap <= gap - 1;
        end
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    wait (stim_done);
    while (expected_roots.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_roots.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
